// ===== hw/rtl/sbg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the segmented bar gauge fill block.
// Used by the divider, front end, back end and top level; depends on nothing.
package sbg_pkg;

    localparam int SEGMENTS_DEF = 32;

    localparam int READ_W    = 16;
    localparam int SPAN_W    = 13;
    localparam int REDLINE_W = 6;
    localparam int LIT_W     = 8;
    localparam int HOT_W     = 7;
    localparam int OUT_IDX_W = 5;
    localparam int PROD_W    = SPAN_W + LIT_W;
    localparam int DIV_CNT_W = 3;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_ADDR_W-1:0] REG_SPAN    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REDLINE = 1'd1;

    localparam logic [SPAN_W-1:0]    SPAN_RESET    = 13'd250;
    localparam logic [REDLINE_W-1:0] REDLINE_RESET = 6'd27;

    localparam logic [LIT_W-1:0] LIT_EMPTY = 8'd0;
    localparam logic [LIT_W-1:0] LIT_FULL  = 8'd255;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic              start;
        logic [SPAN_W-1:0] share;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [LIT_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== hw/rtl/sbg_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sbg_div.sv =====
`timescale 1ns / 1ps
// Restoring divider that scales a partial fill share to an 8-bit opacity,
// one quotient bit per cycle. Depends on sbg_pkg.
module sbg_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sbg_pkg::div_req_t         req,
    input  logic [sbg_pkg::SPAN_W-1:0] span,
    output sbg_pkg::div_rsp_t         rsp
);
    import sbg_pkg::*;

    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [LIT_W-1:0]     quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [PROD_W-1:0]    divisor;
    logic                 fits;

    assign divisor = PROD_W'(span) << cnt_reg;
    assign fits    = (rem_reg >= divisor);

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (req.start)
        begin
            rem_next  = {req.share, {LIT_W{1'b0}}} - PROD_W'(req.share);
            quot_next = '0;
            cnt_next  = DIV_CNT_W'(LIT_W - 1);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - divisor;
            end
            quot_next = {quot_reg[LIT_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== hw/rtl/sbg_queue.sv =====
`timescale 1ns / 1ps
// Short first-in first-out queue that decouples the segment walker from the
// change filter. Depends on nothing.
module sbg_queue #(
    parameter int DATA_W = 15,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              q_full,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              q_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_wr, do_rd;

    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/sbg_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts a speed reading, walks the segments with a running base
// and classifies each one as empty, full or partial. Depends on sbg_pkg and sbg_div.
module sbg_front #(
    parameter int SEGMENTS = sbg_pkg::SEGMENTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [sbg_pkg::READ_W-1:0]           speed_reading,
    input  logic [sbg_pkg::SPAN_W-1:0]           span,
    input  logic                                 q_full,
    output logic                                 q_wr,
    output logic [$clog2(SEGMENTS)+sbg_pkg::LIT_W:0] q_wdata
);
    import sbg_pkg::*;

    localparam int IDX_W  = $clog2(SEGMENTS);
    localparam int BASE_W = (SPAN_W + IDX_W > READ_W) ? SPAN_W + IDX_W : READ_W;
    localparam int DIFF_W = BASE_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [READ_W-1:0] read_reg, read_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic [DIFF_W-1:0] diff;
    logic              seg_empty, seg_full, seg_last;
    logic [LIT_W-1:0]  lit;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    sbg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .span  (span),
        .rsp   (div_rsp)
    );

    assign diff      = DIFF_W'(read_reg) - DIFF_W'(base_reg);
    assign seg_empty = diff[DIFF_W-1] || (diff == '0);
    assign seg_full  = !seg_empty && (diff >= DIFF_W'(span));
    assign seg_last  = (idx_reg == IDX_W'(SEGMENTS - 1));
    assign full      = (state_reg != ST_IDLE);
    assign q_wdata   = {idx_reg, lit, seg_last};

    always_comb
    begin
        state_next    = state_reg;
        read_next     = read_reg;
        base_next     = base_reg;
        idx_next      = idx_reg;
        q_wr          = 1'b0;
        lit           = LIT_EMPTY;
        div_req.start = 1'b0;
        div_req.share = diff[SPAN_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    read_next  = speed_reading;
                    base_next  = '0;
                    idx_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                lit = seg_full ? LIT_FULL : LIT_EMPTY;
                if (!seg_empty && !seg_full)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    q_wr = !q_full;
                end
            end
            ST_DIV:
            begin
                lit  = div_rsp.quot;
                q_wr = div_rsp.done && !q_full;
                if (q_wr)
                begin
                    state_next = ST_WALK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (q_wr)
        begin
            base_next = base_reg + BASE_W'(span);
            idx_next  = idx_reg + 1'b1;
            if (seg_last)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_reg <= read_next;
        base_reg <= base_next;
        idx_reg  <= idx_next;
    end

endmodule

// ===== hw/rtl/sbg_back.sv =====
`timescale 1ns / 1ps
// Back end: compares each segment word with the last shown fill, keeps one
// change in hand to mark the final one, and drives the result register.
// Depends on sbg_pkg and sbg_ram.
module sbg_back #(
    parameter int SEGMENTS = sbg_pkg::SEGMENTS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [sbg_pkg::REDLINE_W-1:0]            redline,
    input  logic                                     q_empty,
    input  logic [$clog2(SEGMENTS)+sbg_pkg::LIT_W:0] q_rdata,
    output logic                                     q_rd,
    output logic                                     empty,
    input  logic                                     pop,
    output logic [sbg_pkg::OUT_IDX_W-1:0]            segment_index,
    output logic [sbg_pkg::LIT_W-1:0]                lit_opacity,
    output logic [sbg_pkg::HOT_W-1:0]                hot_opacity,
    output logic                                     last_change
);
    import sbg_pkg::*;

    localparam int IDX_W = $clog2(SEGMENTS);

    logic                 s1_valid_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic [LIT_W-1:0]     s1_lit_reg;
    logic                 s1_last_reg;

    logic                 hold_valid_reg;
    logic                 hold_final_reg;
    logic [IDX_W-1:0]     hold_idx_reg;
    logic [LIT_W-1:0]     hold_lit_reg;
    logic [HOT_W-1:0]     hold_hot_reg;

    logic                 out_valid_reg;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    logic [LIT_W-1:0]     out_lit_reg;
    logic [HOT_W-1:0]     out_hot_reg;
    logic                 out_last_reg;

    logic [SEGMENTS-1:0]  seen_reg;

    logic [IDX_W-1:0]     head_idx;
    logic [LIT_W-1:0]     shown_lit;
    logic                 changed, out_free, hold_go, s1_done, advance, take_change;
    logic [HOT_W-1:0]     hot;

    assign head_idx = q_rdata[LIT_W+IDX_W:LIT_W+1];

    sbg_ram #(
        .WIDTH (LIT_W),
        .DEPTH (SEGMENTS)
    ) u_shown (
        .clk   (clk),
        .we    (take_change),
        .waddr (s1_idx_reg),
        .wdata (s1_lit_reg),
        .re    (q_rd),
        .raddr (head_idx),
        .rdata (shown_lit)
    );

    assign changed     = !seen_reg[s1_idx_reg] || (shown_lit != s1_lit_reg);
    assign out_free    = !out_valid_reg || pop;
    assign hold_go     = hold_valid_reg && out_free
                         && (hold_final_reg || (s1_valid_reg && changed));
    assign s1_done     = s1_valid_reg && (!changed || !hold_valid_reg || hold_go);
    assign take_change = s1_done && changed;
    assign advance     = !s1_valid_reg || s1_done;
    assign q_rd        = advance && !q_empty;
    assign hot         = (REDLINE_W'(s1_idx_reg) >= redline) ? s1_lit_reg[LIT_W-1:1] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            seen_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= !q_empty;
            end
            if (take_change)
            begin
                seen_reg[s1_idx_reg] <= 1'b1;
                hold_valid_reg       <= 1'b1;
                hold_final_reg       <= s1_last_reg;
            end
            else if (hold_go)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (s1_done && s1_last_reg && hold_valid_reg)
            begin
                hold_final_reg <= 1'b1;
            end
            if (hold_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            s1_idx_reg  <= head_idx;
            s1_lit_reg  <= q_rdata[LIT_W:1];
            s1_last_reg <= q_rdata[0];
        end
        if (take_change)
        begin
            hold_idx_reg <= s1_idx_reg;
            hold_lit_reg <= s1_lit_reg;
            hold_hot_reg <= hot;
        end
        if (hold_go)
        begin
            out_idx_reg  <= OUT_IDX_W'(hold_idx_reg);
            out_lit_reg  <= hold_lit_reg;
            out_hot_reg  <= hold_hot_reg;
            out_last_reg <= hold_final_reg;
        end
    end

    assign empty         = !out_valid_reg;
    assign segment_index = out_idx_reg;
    assign lit_opacity   = out_lit_reg;
    assign hot_opacity   = out_hot_reg;
    assign last_change   = out_last_reg;

`ifndef SYNTH
    a_hold_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_go |=> out_valid_reg)
        else $error("held change did not reach the result register");
    a_seen_set: assert property (@(posedge clk) disable iff (!rst_n)
        take_change |=> seen_reg[$past(s1_idx_reg)])
        else $error("shown fill entry written without its valid bit");
    a_change_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && changed && hold_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("changed word dropped while the hold slot was busy");
`endif

endmodule

// ===== hw/rtl/segmented_bar_gauge_fill.sv =====
`timescale 1ns / 1ps
// Top level of the segmented bar gauge fill block: configuration registers,
// front end, word queue and back end. Depends on sbg_pkg and all sbg_ modules.
//
// Each speed reading is walked segment by segment in the front end; the one
// partly filled segment, if any, waits while a bit-serial divider works out
// its 8-bit opacity. Full stays high while a reading is being walked. The back
// end drains one segment word per cycle, while the consumer keeps popping,
// through a four-word queue and a registered result stage, so a slow consumer
// stalls the walk only once the queue fills.
module segmented_bar_gauge_fill #(
    parameter int SEGMENTS = sbg_pkg::SEGMENTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [sbg_pkg::READ_W-1:0]        speed_reading,
    output logic                              empty,
    input  logic                              pop,
    output logic [sbg_pkg::OUT_IDX_W-1:0]     segment_index,
    output logic [sbg_pkg::LIT_W-1:0]         lit_opacity,
    output logic [sbg_pkg::HOT_W-1:0]         hot_opacity,
    output logic                              last_change,
    input  logic                              cfg_we,
    input  logic [sbg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sbg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sbg_pkg::*;

    localparam int WORD_W = $clog2(SEGMENTS) + LIT_W + 1;

    logic [SPAN_W-1:0]    span_reg;
    logic [REDLINE_W-1:0] redline_reg;
    logic [SPAN_W-1:0]    span_eff;
    logic                 q_full, q_empty, q_wr, q_rd;
    logic [WORD_W-1:0]    q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg    <= SPAN_RESET;
            redline_reg <= REDLINE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SPAN:    span_reg    <= cfg_data[SPAN_W-1:0];
                REG_REDLINE: redline_reg <= cfg_data[REDLINE_W-1:0];
                default:     ;
            endcase
        end
    end

    assign span_eff = (span_reg == '0) ? SPAN_W'(1) : span_reg;

    sbg_front #(
        .SEGMENTS (SEGMENTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .speed_reading (speed_reading),
        .span          (span_eff),
        .q_full        (q_full),
        .q_wr          (q_wr),
        .q_wdata       (q_wdata)
    );

    sbg_queue #(
        .DATA_W (WORD_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .q_empty (q_empty)
    );

    sbg_back #(
        .SEGMENTS (SEGMENTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .redline       (redline_reg),
        .q_empty       (q_empty),
        .q_rdata       (q_rdata),
        .q_rd          (q_rd),
        .empty         (empty),
        .pop           (pop),
        .segment_index (segment_index),
        .lit_opacity   (lit_opacity),
        .hot_opacity   (hot_opacity),
        .last_change   (last_change)
    );

endmodule

// ===== tb/tb_segmented_bar_gauge_fill.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for segmented_bar_gauge_fill: feeds speed readings, predicts
// the changed segment words and compares every popped word against the prediction.
// Depends on sbg_pkg and the segmented_bar_gauge_fill RTL.
module tb_segmented_bar_gauge_fill;

    import sbg_pkg::*;

    localparam int          SEG_COUNT     = SEGMENTS_DEF;
    localparam int          SETTLE_CYCLES = 120;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] seg;
        logic [LIT_W-1:0]     lit;
        logic [HOT_W-1:0]     hot;
        logic                 last_flag;
    } seg_word_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [READ_W-1:0]     speed_reading = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [OUT_IDX_W-1:0]  segment_index;
    logic [LIT_W-1:0]      lit_opacity;
    logic [HOT_W-1:0]      hot_opacity;
    logic                  last_change;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [READ_W-1:0]     readings_pending[$];
    seg_word_t             fill_words_due[$];
    seg_word_t             due_word;
    logic [8:0]            model_shown[SEG_COUNT];
    logic [SPAN_W-1:0]     model_span;
    logic [REDLINE_W-1:0]  model_redline;
    logic [READ_W-1:0]     last_reading;
    int                    send_idle_pct = 0;
    int                    stall_pct = 0;
    int                    fail_count = 0;
    int unsigned           cycle_count = 0;

    segmented_bar_gauge_fill i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .speed_reading (speed_reading),
        .empty         (empty),
        .pop           (pop),
        .segment_index (segment_index),
        .lit_opacity   (lit_opacity),
        .hot_opacity   (hot_opacity),
        .last_change   (last_change),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void predict_segment_fill(input logic [READ_W-1:0] reading);
        int unsigned span;
        int unsigned rd;
        int unsigned base;
        int unsigned share;
        int unsigned lit;
        int unsigned hot;
        int          n_words;
        seg_word_t   w;
        span = (model_span == 0) ? 1 : model_span;
        rd = reading;
        n_words = 0;
        if (rd > span * SEG_COUNT)
            rd = span * SEG_COUNT;
        for (int unsigned i = 0; i < SEG_COUNT; i++)
        begin
            base = span * i;
            if (rd <= base)
                share = 0;
            else if (rd - base >= span)
                share = span;
            else
                share = rd - base;
            lit = (share * 255) / span;
            if (lit == model_shown[i])
                continue;
            model_shown[i] = lit[8:0];
            hot = (i >= model_redline) ? (share * 255) / (2 * span) : 0;
            w.seg = i[OUT_IDX_W-1:0];
            w.lit = lit[LIT_W-1:0];
            w.hot = hot[HOT_W-1:0];
            w.last_flag = 1'b0;
            fill_words_due.push_back(w);
            n_words++;
        end
        if (n_words > 0)
            fill_words_due[fill_words_due.size()-1].last_flag = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            speed_reading <= '0;
        end
        else
        begin
            if (push && !full)
                predict_segment_fill(speed_reading);
            if (!(push && full))
            begin
                if (readings_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    speed_reading <= readings_pending.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (fill_words_due.size() == 0)
                begin
                    $error("unexpected word: segment_index %0d", segment_index);
                    fail_count++;
                end
                else
                begin
                    due_word = fill_words_due.pop_front();
                    if (segment_index !== due_word.seg)
                    begin
                        $error("segment_index: expected %0d, actual %0d",
                               due_word.seg, segment_index);
                        fail_count++;
                    end
                    if (lit_opacity !== due_word.lit)
                    begin
                        $error("lit_opacity: expected %0d, actual %0d",
                               due_word.lit, lit_opacity);
                        fail_count++;
                    end
                    if (hot_opacity !== due_word.hot)
                    begin
                        $error("hot_opacity: expected %0d, actual %0d",
                               due_word.hot, hot_opacity);
                        fail_count++;
                    end
                    if (last_change !== due_word.last_flag)
                    begin
                        $error("last_change: expected %0d, actual %0d",
                               due_word.last_flag, last_change);
                        fail_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_SPAN)
            model_span = data[SPAN_W-1:0];
        else if (addr == REG_REDLINE)
            model_redline = data[REDLINE_W-1:0];
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (readings_pending.size() != 0 || push || fill_words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic feed(input logic [READ_W-1:0] reading);
        readings_pending.push_back(reading);
        last_reading = reading;
    endtask

    function automatic logic [READ_W-1:0] random_reading();
        int unsigned span;
        int unsigned top;
        int unsigned pick;
        int unsigned k;
        span = (model_span == 0) ? 1 : model_span;
        top = span * (SEG_COUNT + 1);
        if (top > 65535)
            top = 65535;
        pick = $urandom_range(99);
        if (pick < 60)
            return READ_W'($urandom_range(top, 0));
        if (pick < 75)
            return READ_W'($urandom_range(65535, 0));
        if (pick < 90)
            return last_reading;
        k = span * $urandom_range(SEG_COUNT, 0) + $urandom_range(2, 0);
        k = (k == 0) ? 0 : k - 1;
        return (k > 65535) ? 16'hFFFF : k[READ_W-1:0];
    endfunction

    function automatic logic [SPAN_W-1:0] random_span();
        case ($urandom_range(4, 0))
            0: return SPAN_W'($urandom_range(16, 1));
            1: return SPAN_W'($urandom_range(400, 17));
            2: return SPAN_W'($urandom_range(2047, 401));
            3: return SPAN_W'($urandom_range(8191, 2048));
            default: return SPAN_W'($urandom_range(1, 0));
        endcase
    endfunction

    initial
    begin
        model_span = SPAN_RESET;
        model_redline = REDLINE_RESET;
        last_reading = '0;
        for (int i = 0; i < SEG_COUNT; i++)
            model_shown[i] = 9'd511;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        feed(16'd0);
        feed(16'd0);
        feed(16'd125);
        feed(16'd7999);
        feed(16'd8000);
        feed(16'hFFFF);
        feed(16'd4321);
        wait_idle();

        write_register(REG_SPAN, 13'd0);
        write_register(REG_REDLINE, 13'd0);
        feed(16'd0);
        feed(16'd1);
        feed(16'd31);
        feed(16'd32);
        feed(16'd33);
        feed(16'd16);
        wait_idle();

        write_register(REG_SPAN, 13'd4096);
        write_register(REG_REDLINE, 13'd32);
        feed(16'd0);
        feed(16'hFFFF);
        feed(16'hFFFF);
        feed(16'd2048);
        wait_idle();

        write_register(REG_SPAN, 13'h1FFF);
        write_register(REG_REDLINE, 13'd63);
        feed(16'd8190);
        feed(16'hFFFF);
        wait_idle();

        write_register(REG_SPAN, 13'd1);
        write_register(REG_REDLINE, 13'd31);
        feed(16'hAAAA);
        feed(16'd17);
        wait_idle();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 81 : (phase == 3) ? 17 : 0;
            stall_pct = (phase == 2) ? 81 : (phase == 3) ? 17 : 0;
            write_register(REG_SPAN, random_span());
            write_register(REG_REDLINE, ($urandom_range(9) == 0) ? 13'd63
                                        : CFG_DATA_W'($urandom_range(40, 0)));
            for (int n = 0; n < 28; n++)
            begin
                feed(random_reading());
                if (phase == 1 && n == 13)
                    wait_idle();
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
